### hdl/equatorial_to_horizontal_core_assert.svh
// --------------------------------------------------------------------------
// equatorial_to_horizontal_core assertion macros
// concurrent checks, removed when NO_ASSERTIONS is defined
// --------------------------------------------------------------------------
`ifndef EQUATORIAL_TO_HORIZONTAL_CORE_ASSERT_SVH
`define EQUATORIAL_TO_HORIZONTAL_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition holds at every edge out of reset
`define E2H_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("e2h check failed");

// same-cycle implication
`define E2H_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("e2h check failed");

// next-cycle implication
`define E2H_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("e2h check failed");

`else

`define E2H_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define E2H_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons)
`define E2H_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

### hdl/e2h_pkg.sv
`timescale 1ns / 1ps
// --------------------------------------------------------------------------
// e2h_pkg
// shared types, constants and cordic tables for the coordinate converter
// --------------------------------------------------------------------------
package e2h_pkg;

  // internal datapath width for cordic x, y, z
  localparam int W = 34;

  localparam logic signed [W-1:0] HALF_PI  = 34'sd843314857;
  localparam logic signed [W-1:0] PI       = 34'sd1686629713;
  localparam logic signed [W-1:0] GAIN     = 34'sd652032874;
  localparam logic signed [31:0]  ONE_Q30  = 32'sd1073741824;
  localparam logic [61:0]         ONE_Q60  = 62'd1 << 60;

  localparam logic signed [30:0]  LAT_RESET = 31'sd491933666;

  // register index, taken from byte address bit 2
  localparam logic REG_LATITUDE = 1'b0;

  localparam int SQRT_STEPS = 31;
  localparam int DIV_STEPS  = 31;

  localparam logic signed [31:0] ATAN_LOW [10] = '{
    32'sd421657428, 32'sd248918915, 32'sd131521918, 32'sd66762579,
    32'sd33510843,  32'sd16771758,  32'sd8387925,   32'sd4194219,
    32'sd2097141,   32'sd1048575
  };

  typedef struct packed {
    logic signed [30:0] declination;
    logic signed [31:0] hour_angle;
  } in_item_t;

  typedef struct packed {
    logic signed [30:0] altitude;
    logic [30:0]        azimuth;
    logic               azimuth_undefined;
  } out_item_t;

  typedef struct packed {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [W-1:0] z;
    logic                neg;
  } rot_lane_t;

  typedef struct packed {
    rot_lane_t dec;
    rot_lane_t lat;
    rot_lane_t ha;
  } rot_set_t;

  typedef struct packed {
    logic signed [W-1:0] x;
    logic signed [W-1:0] y;
    logic signed [W-1:0] z;
  } vec_t;

  typedef struct packed {
    logic [33:0] rem;
    logic [30:0] root;
    logic [61:0] rad;
  } sqrt_t;

  typedef struct packed {
    logic [31:0] rem;
    logic [30:0] q;
    logic [31:0] d;
    logic [30:0] lo;
  } div_t;

  function automatic logic signed [31:0] atan_q29(input int i);
    logic signed [31:0] r;
    if (i < 10) begin
      r = ATAN_LOW[i[3:0]];
    end else if (i < 30) begin
      r = 32'sd1 <<< (29 - i);
    end else begin
      r = '0;
    end
    return r;
  endfunction

  // fold angle into +-pi/2 and seed the rotation
  function automatic rot_lane_t rot_prep(input logic signed [W-1:0] a);
    rot_lane_t l;
    l.x   = GAIN;
    l.y   = '0;
    l.z   = a;
    l.neg = 1'b0;
    if (a > HALF_PI) begin
      l.z   = a - PI;
      l.neg = 1'b1;
    end else if (a < -HALF_PI) begin
      l.z   = a + PI;
      l.neg = 1'b1;
    end
    return l;
  endfunction

endpackage

### hdl/e2h_rot_cell.sv
`timescale 1ns / 1ps
// --------------------------------------------------------------------------
// e2h_rot_cell
// one cordic rotation iteration on three angle lanes
// --------------------------------------------------------------------------
module e2h_rot_cell import e2h_pkg::*; #(
  parameter int IDX = 0
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     en,
  input  logic     in_valid,
  input  rot_set_t in_set,
  output logic     out_valid,
  output rot_set_t out_set
);

  localparam logic signed [W-1:0] ATAN = W'(atan_q29(IDX));

  logic     valid_r;
  rot_set_t set_r;
  rot_set_t set_nxt;

  function automatic rot_lane_t step(input rot_lane_t l);
    rot_lane_t o;
    o = l;
    if (!l.z[W-1]) begin
      o.x = l.x - (l.y >>> IDX);
      o.y = l.y + (l.x >>> IDX);
      o.z = l.z - ATAN;
    end else begin
      o.x = l.x + (l.y >>> IDX);
      o.y = l.y - (l.x >>> IDX);
      o.z = l.z + ATAN;
    end
    return o;
  endfunction

  always_comb begin
    set_nxt.dec = step(in_set.dec);
    set_nxt.lat = step(in_set.lat);
    set_nxt.ha  = step(in_set.ha);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      set_r <= set_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_set   = set_r;

endmodule

### hdl/e2h_vec_cell.sv
`timescale 1ns / 1ps
// --------------------------------------------------------------------------
// e2h_vec_cell
// one cordic vectoring iteration, drives y toward zero
// --------------------------------------------------------------------------
module e2h_vec_cell import e2h_pkg::*; #(
  parameter int IDX  = 0,
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  vec_t            in_st,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_valid,
  output vec_t            out_st,
  output logic [SB_W-1:0] out_sb
);

  localparam logic signed [W-1:0] ATAN = W'(atan_q29(IDX));

  logic            valid_r;
  vec_t            st_r;
  vec_t            st_nxt;
  logic [SB_W-1:0] sb_r;

  always_comb begin
    if (!in_st.y[W-1]) begin
      st_nxt.x = in_st.x + (in_st.y >>> IDX);
      st_nxt.y = in_st.y - (in_st.x >>> IDX);
      st_nxt.z = in_st.z + ATAN;
    end else begin
      st_nxt.x = in_st.x - (in_st.y >>> IDX);
      st_nxt.y = in_st.y + (in_st.x >>> IDX);
      st_nxt.z = in_st.z - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
      sb_r <= in_sb;
    end
  end

  assign out_valid = valid_r;
  assign out_st    = st_r;
  assign out_sb    = sb_r;

endmodule

### hdl/e2h_sqrt_cell.sv
`timescale 1ns / 1ps
// --------------------------------------------------------------------------
// e2h_sqrt_cell
// one digit of a restoring floor square root
// --------------------------------------------------------------------------
module e2h_sqrt_cell import e2h_pkg::*; #(
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  sqrt_t           in_st,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_valid,
  output sqrt_t           out_st,
  output logic [SB_W-1:0] out_sb
);

  logic            valid_r;
  sqrt_t           st_r;
  sqrt_t           st_nxt;
  logic [SB_W-1:0] sb_r;
  logic [35:0]     rem_w;
  logic [35:0]     trial;

  always_comb begin
    rem_w      = {in_st.rem, in_st.rad[61:60]};
    trial      = {3'b000, in_st.root, 2'b01};
    st_nxt.rad = {in_st.rad[59:0], 2'b00};
    if (rem_w >= trial) begin
      st_nxt.rem  = 34'(rem_w - trial);
      st_nxt.root = {in_st.root[29:0], 1'b1};
    end else begin
      st_nxt.rem  = rem_w[33:0];
      st_nxt.root = {in_st.root[29:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
      sb_r <= in_sb;
    end
  end

  assign out_valid = valid_r;
  assign out_st    = st_r;
  assign out_sb    = sb_r;

endmodule

### hdl/e2h_div_cell.sv
`timescale 1ns / 1ps
// --------------------------------------------------------------------------
// e2h_div_cell
// one quotient bit of a restoring unsigned divider
// --------------------------------------------------------------------------
module e2h_div_cell import e2h_pkg::*; #(
  parameter int SB_W = 1
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  div_t            in_st,
  input  logic [SB_W-1:0] in_sb,
  output logic            out_valid,
  output div_t            out_st,
  output logic [SB_W-1:0] out_sb
);

  logic            valid_r;
  div_t            st_r;
  div_t            st_nxt;
  logic [SB_W-1:0] sb_r;
  logic [32:0]     rem_w;

  always_comb begin
    rem_w     = {in_st.rem, in_st.lo[30]};
    st_nxt.d  = in_st.d;
    st_nxt.lo = {in_st.lo[29:0], 1'b0};
    if (rem_w >= {1'b0, in_st.d}) begin
      st_nxt.rem = 32'(rem_w - {1'b0, in_st.d});
      st_nxt.q   = {in_st.q[29:0], 1'b1};
    end else begin
      st_nxt.rem = rem_w[31:0];
      st_nxt.q   = {in_st.q[29:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r <= st_nxt;
      sb_r <= in_sb;
    end
  end

  assign out_valid = valid_r;
  assign out_st    = st_r;
  assign out_sb    = sb_r;

endmodule

### hdl/equatorial_to_horizontal_core.sv
`timescale 1ns / 1ps
// --------------------------------------------------------------------------
// equatorial_to_horizontal_core
// declination and hour angle in, altitude and acos azimuth out
// --------------------------------------------------------------------------
// usage:
//   in_valid/in_stall take one request (declination, hour_angle, Q29 rad).
//   out_valid/out_stall give one result (altitude, azimuth, undefined flag).
//   latitude is written over the apb port at address 0; the user must write it
//   only while the core idles, which the core itself does not enforce.
// throughput: one request per cycle while the output queue is not full; the
//   datapath is a chain of cordic, square root and divider cells, each doing
//   one iteration per cycle.
// stall: results land in a two-entry output queue; the chain freezes only
//   when that queue is full, and in_stall is high in exactly those cycles,
//   so requests wait until a result leaves the queue.
// reset: clears all valid bits and the queue, latitude returns to its
//   default; no clearing pass is needed.
// --------------------------------------------------------------------------
`include "equatorial_to_horizontal_core_assert.svh"

module equatorial_to_horizontal_core import e2h_pkg::*; #(
  parameter int CORDIC_STAGES = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_item_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int N = CORDIC_STAGES;

  typedef struct packed {
    logic signed [31:0]  s;
    logic signed [W-1:0] sd;
    logic signed [W-1:0] sl;
    logic signed [W-1:0] cl;
  } sb1_t;

  typedef struct packed {
    logic [30:0]         ca;
    logic signed [31:0]  s;
    logic signed [W-1:0] sd;
    logic signed [W-1:0] sl;
    logic signed [W-1:0] cl;
  } sb2_t;

  typedef struct packed {
    logic signed [30:0] alt;
    logic               sign;
    logic               ovf;
    logic               undef;
  } sb3_t;

  typedef struct packed {
    logic signed [31:0] t;
    logic signed [30:0] alt;
    logic               undef;
  } sb4_t;

  typedef struct packed {
    logic signed [30:0] alt;
    logic               undef;
  } sb5_t;

  logic en;

  // ---------------- configuration ----------------
  logic signed [30:0] lat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lat_r <= LAT_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_LATITUDE) begin
      lat_r <= pwdata[30:0];
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_LATITUDE) ? {1'b0, lat_r} : '0;

  // ---------------- angle fold ----------------
  logic     pre_valid_r;
  rot_set_t pre_set_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre_valid_r <= 1'b0;
    end else if (en) begin
      pre_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pre_set_r.dec <= rot_prep(W'(in_data.declination));
      pre_set_r.lat <= rot_prep(W'(lat_r));
      pre_set_r.ha  <= rot_prep(W'(in_data.hour_angle));
    end
  end

  // ---------------- sin/cos chain ----------------
  logic     rot_v   [N+1];
  rot_set_t rot_set [N+1];

  assign rot_v[0]   = pre_valid_r;
  assign rot_set[0] = pre_set_r;

  for (genvar i = 0; i < N; i++) begin : g_rot
    e2h_rot_cell #(.IDX(i)) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(rot_v[i]),   .in_set(rot_set[i]),
      .out_valid(rot_v[i+1]), .out_set(rot_set[i+1])
    );
  end

  // ---------------- sin(alt) products ----------------
  logic                m1_v_r, m2_v_r, m3_v_r, m4_v_r, m5_v_r;
  logic signed [W-1:0] m1_sd_r, m1_cd_r, m1_sl_r, m1_cl_r, m1_ch_r;
  logic signed [67:0]  m2_p1_r, m2_p2_r;
  logic signed [W-1:0] m2_sd_r, m2_sl_r, m2_cl_r, m2_ch_r;
  logic signed [W-1:0] m3_q1_r;
  logic signed [67:0]  m3_p3_r;
  logic signed [W-1:0] m3_sd_r, m3_sl_r, m3_cl_r;
  logic signed [35:0]  m4_sum;
  logic signed [31:0]  m4_s_nxt;
  logic signed [31:0]  m4_s_r;
  logic signed [W-1:0] m4_sd_r, m4_sl_r, m4_cl_r;
  logic signed [63:0]  m5_ss;
  logic [61:0]         m5_rad_r;
  sb1_t                m5_sb_r;

  always_comb begin
    m4_sum = 36'(m3_q1_r) + 36'(m3_p3_r >>> 30);
    if (m4_sum > 36'(ONE_Q30)) begin
      m4_s_nxt = ONE_Q30;
    end else if (m4_sum < -36'(ONE_Q30)) begin
      m4_s_nxt = -ONE_Q30;
    end else begin
      m4_s_nxt = 32'(m4_sum);
    end
    m5_ss = m4_s_r * m4_s_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
      m2_v_r <= 1'b0;
      m3_v_r <= 1'b0;
      m4_v_r <= 1'b0;
      m5_v_r <= 1'b0;
    end else if (en) begin
      m1_v_r <= rot_v[N];
      m2_v_r <= m1_v_r;
      m3_v_r <= m2_v_r;
      m4_v_r <= m3_v_r;
      m5_v_r <= m4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // undo the pi fold
      m1_sd_r <= rot_set[N].dec.neg ? -rot_set[N].dec.y : rot_set[N].dec.y;
      m1_cd_r <= rot_set[N].dec.neg ? -rot_set[N].dec.x : rot_set[N].dec.x;
      m1_sl_r <= rot_set[N].lat.neg ? -rot_set[N].lat.y : rot_set[N].lat.y;
      m1_cl_r <= rot_set[N].lat.neg ? -rot_set[N].lat.x : rot_set[N].lat.x;
      m1_ch_r <= rot_set[N].ha.neg  ? -rot_set[N].ha.x  : rot_set[N].ha.x;

      m2_p1_r <= m1_sd_r * m1_sl_r;
      m2_p2_r <= m1_cd_r * m1_cl_r;
      m2_sd_r <= m1_sd_r;
      m2_sl_r <= m1_sl_r;
      m2_cl_r <= m1_cl_r;
      m2_ch_r <= m1_ch_r;

      m3_q1_r <= W'(m2_p1_r >>> 30);
      m3_p3_r <= W'(m2_p2_r >>> 30) * m2_ch_r;
      m3_sd_r <= m2_sd_r;
      m3_sl_r <= m2_sl_r;
      m3_cl_r <= m2_cl_r;

      m4_s_r  <= m4_s_nxt;
      m4_sd_r <= m3_sd_r;
      m4_sl_r <= m3_sl_r;
      m4_cl_r <= m3_cl_r;

      m5_rad_r   <= ONE_Q60 - m5_ss[61:0];
      m5_sb_r.s  <= m4_s_r;
      m5_sb_r.sd <= m4_sd_r;
      m5_sb_r.sl <= m4_sl_r;
      m5_sb_r.cl <= m4_cl_r;
    end
  end

  // ---------------- cos(alt) square root ----------------
  logic  sq1_v  [SQRT_STEPS+1];
  sqrt_t sq1_st [SQRT_STEPS+1];
  sb1_t  sq1_sb [SQRT_STEPS+1];

  assign sq1_v[0]       = m5_v_r;
  assign sq1_st[0].rem  = '0;
  assign sq1_st[0].root = '0;
  assign sq1_st[0].rad  = m5_rad_r;
  assign sq1_sb[0]      = m5_sb_r;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sq1
    e2h_sqrt_cell #(.SB_W($bits(sb1_t))) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(sq1_v[i]), .in_st(sq1_st[i]), .in_sb(sq1_sb[i]),
      .out_valid(sq1_v[i+1]), .out_st(sq1_st[i+1]), .out_sb(sq1_sb[i+1])
    );
  end

  // ---------------- altitude asin ----------------
  logic v1_v  [N+1];
  vec_t v1_st [N+1];
  sb2_t v1_sb [N+1];

  assign v1_v[0]     = sq1_v[SQRT_STEPS];
  assign v1_st[0].x  = $signed({3'b000, sq1_st[SQRT_STEPS].root});
  assign v1_st[0].y  = W'(sq1_sb[SQRT_STEPS].s);
  assign v1_st[0].z  = '0;
  assign v1_sb[0].ca = sq1_st[SQRT_STEPS].root;
  assign v1_sb[0].s  = sq1_sb[SQRT_STEPS].s;
  assign v1_sb[0].sd = sq1_sb[SQRT_STEPS].sd;
  assign v1_sb[0].sl = sq1_sb[SQRT_STEPS].sl;
  assign v1_sb[0].cl = sq1_sb[SQRT_STEPS].cl;

  for (genvar i = 0; i < N; i++) begin : g_v1
    e2h_vec_cell #(.IDX(i), .SB_W($bits(sb2_t))) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(v1_v[i]), .in_st(v1_st[i]), .in_sb(v1_sb[i]),
      .out_valid(v1_v[i+1]), .out_st(v1_st[i+1]), .out_sb(v1_sb[i+1])
    );
  end

  // ---------------- azimuth quotient setup ----------------
  logic                d1_v_r, d2_v_r, d3_v_r;
  logic signed [W-1:0] alt_z;
  logic signed [30:0]  d1_alt_r, d2_alt_r;
  logic signed [65:0]  d1_denp_r, d1_nsp_r;
  logic signed [W-1:0] d1_sd_r;
  logic signed [W-1:0] d2_den_r, d2_num_r;
  logic [W-1:0]        d2_an, d2_ad;
  div_t                d3_st_r;
  sb3_t                d3_sb_r;

  always_comb begin
    alt_z = v1_st[N].z;
    if (alt_z > HALF_PI) begin
      alt_z = HALF_PI;
    end else if (alt_z < -HALF_PI) begin
      alt_z = -HALF_PI;
    end
    d2_an = d2_num_r[W-1] ? W'(-d2_num_r) : d2_num_r;
    d2_ad = d2_den_r[W-1] ? W'(-d2_den_r) : d2_den_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d1_v_r <= 1'b0;
      d2_v_r <= 1'b0;
      d3_v_r <= 1'b0;
    end else if (en) begin
      d1_v_r <= v1_v[N];
      d2_v_r <= d1_v_r;
      d3_v_r <= d2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_alt_r  <= 31'(alt_z);
      d1_denp_r <= $signed({3'b000, v1_sb[N].ca}) * v1_sb[N].cl;
      d1_nsp_r  <= W'(v1_sb[N].s) * v1_sb[N].sl;
      d1_sd_r   <= v1_sb[N].sd;

      d2_alt_r  <= d1_alt_r;
      d2_den_r  <= W'(d1_denp_r >>> 30);
      d2_num_r  <= d1_sd_r - W'(d1_nsp_r >>> 30);

      // quotient below 2^31 unless |num| >= 2|den|
      d3_st_r.rem   <= d2_an[32:1];
      d3_st_r.q     <= '0;
      d3_st_r.d     <= d2_ad[31:0];
      d3_st_r.lo    <= {d2_an[0], 30'b0};
      d3_sb_r.alt   <= d2_alt_r;
      d3_sb_r.sign  <= d2_num_r[W-1] ^ d2_den_r[W-1];
      d3_sb_r.ovf   <= d2_an >= {d2_ad[W-2:0], 1'b0};
      d3_sb_r.undef <= d2_den_r == '0;
    end
  end

  // ---------------- divider ----------------
  logic dv_v  [DIV_STEPS+1];
  div_t dv_st [DIV_STEPS+1];
  sb3_t dv_sb [DIV_STEPS+1];

  assign dv_v[0]  = d3_v_r;
  assign dv_st[0] = d3_st_r;
  assign dv_sb[0] = d3_sb_r;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
    e2h_div_cell #(.SB_W($bits(sb3_t))) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(dv_v[i]), .in_st(dv_st[i]), .in_sb(dv_sb[i]),
      .out_valid(dv_v[i+1]), .out_st(dv_st[i+1]), .out_sb(dv_sb[i+1])
    );
  end

  // ---------------- acos argument ----------------
  logic               d4_v_r, d5_v_r;
  logic [30:0]        t_mag;
  logic signed [31:0] d4_t_r;
  logic signed [30:0] d4_alt_r;
  logic               d4_undef_r;
  logic signed [63:0] d5_tt;
  logic [61:0]        d5_rad_r;
  sb4_t               d5_sb_r;

  always_comb begin
    if (dv_sb[DIV_STEPS].ovf || dv_st[DIV_STEPS].q > ONE_Q30[30:0]) begin
      t_mag = ONE_Q30[30:0];
    end else begin
      t_mag = dv_st[DIV_STEPS].q;
    end
    d5_tt = d4_t_r * d4_t_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d4_v_r <= 1'b0;
      d5_v_r <= 1'b0;
    end else if (en) begin
      d4_v_r <= dv_v[DIV_STEPS];
      d5_v_r <= d4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d4_t_r     <= dv_sb[DIV_STEPS].sign ? -$signed({1'b0, t_mag}) : $signed({1'b0, t_mag});
      d4_alt_r   <= dv_sb[DIV_STEPS].alt;
      d4_undef_r <= dv_sb[DIV_STEPS].undef;

      d5_rad_r      <= ONE_Q60 - d5_tt[61:0];
      d5_sb_r.t     <= d4_t_r;
      d5_sb_r.alt   <= d4_alt_r;
      d5_sb_r.undef <= d4_undef_r;
    end
  end

  // ---------------- sqrt(1 - t^2) ----------------
  logic  sq2_v  [SQRT_STEPS+1];
  sqrt_t sq2_st [SQRT_STEPS+1];
  sb4_t  sq2_sb [SQRT_STEPS+1];

  assign sq2_v[0]       = d5_v_r;
  assign sq2_st[0].rem  = '0;
  assign sq2_st[0].root = '0;
  assign sq2_st[0].rad  = d5_rad_r;
  assign sq2_sb[0]      = d5_sb_r;

  for (genvar i = 0; i < SQRT_STEPS; i++) begin : g_sq2
    e2h_sqrt_cell #(.SB_W($bits(sb4_t))) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(sq2_v[i]), .in_st(sq2_st[i]), .in_sb(sq2_sb[i]),
      .out_valid(sq2_v[i+1]), .out_st(sq2_st[i+1]), .out_sb(sq2_sb[i+1])
    );
  end

  // ---------------- azimuth asin ----------------
  logic v2_v  [N+1];
  vec_t v2_st [N+1];
  sb5_t v2_sb [N+1];

  assign v2_v[0]        = sq2_v[SQRT_STEPS];
  assign v2_st[0].x     = $signed({3'b000, sq2_st[SQRT_STEPS].root});
  assign v2_st[0].y     = W'(sq2_sb[SQRT_STEPS].t);
  assign v2_st[0].z     = '0;
  assign v2_sb[0].alt   = sq2_sb[SQRT_STEPS].alt;
  assign v2_sb[0].undef = sq2_sb[SQRT_STEPS].undef;

  for (genvar i = 0; i < N; i++) begin : g_v2
    e2h_vec_cell #(.IDX(i), .SB_W($bits(sb5_t))) u_cell (
      .clk(clk), .rst_n(rst_n), .en(en),
      .in_valid(v2_v[i]), .in_st(v2_st[i]), .in_sb(v2_sb[i]),
      .out_valid(v2_v[i+1]), .out_st(v2_st[i+1]), .out_sb(v2_sb[i+1])
    );
  end

  // ---------------- result and output queue ----------------
  logic signed [W-1:0] az_z;
  logic signed [W-1:0] az;
  out_item_t           res;
  logic                push, pop;
  logic [1:0]          cnt_r, cnt_nxt;
  out_item_t           e0_r, e1_r;

  always_comb begin
    az_z = v2_st[N].z;
    if (az_z > HALF_PI) begin
      az_z = HALF_PI;
    end else if (az_z < -HALF_PI) begin
      az_z = -HALF_PI;
    end
    az = HALF_PI - az_z;
    if (az < '0) begin
      az = '0;
    end else if (az > PI) begin
      az = PI;
    end
    res.altitude          = v2_sb[N].alt;
    res.azimuth_undefined = v2_sb[N].undef;
    res.azimuth           = v2_sb[N].undef ? '0 : az[30:0];
  end

  assign en       = cnt_r != 2'd2;
  assign in_stall = !en;
  assign push     = en && v2_v[N];
  assign pop      = out_valid && !out_stall;
  assign cnt_nxt  = 2'(cnt_r + {1'b0, push} - {1'b0, pop});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((cnt_r == 2'd0 && push) || (cnt_r == 2'd1 && push && pop)) begin
      e0_r <= res;
    end else if (cnt_r == 2'd2 && pop) begin
      e0_r <= e1_r;
    end
    if (cnt_r == 2'd1 && push && !pop) begin
      e1_r <= res;
    end
  end

  assign out_valid = cnt_r != 2'd0;
  assign out_data  = e0_r;

  // ---------------- checks ----------------
  `E2H_ASSERT_ALWAYS(a_queue_bound, clk, rst_n, cnt_r != 2'd3)
  `E2H_ASSERT_IMPLIES(a_stall_full, clk, rst_n, in_stall, cnt_r == 2'd2)
  `E2H_ASSERT_IMPLIES(a_undef_zero, clk, rst_n, out_valid && out_data.azimuth_undefined, out_data.azimuth == '0)
  `E2H_ASSERT_NEXT(a_push_count, clk, rst_n, push && !pop, cnt_r == $past(cnt_r) + 2'd1)

endmodule

### verif/equatorial_to_horizontal_core_tb.sv
`timescale 1ns / 1ps
// --------------------------------------------------------------------------
// equatorial_to_horizontal_core_tb
// converts random and corner star positions under several latitudes and
// compares every altitude/azimuth result against a bit-exact cordic model
// --------------------------------------------------------------------------
module equatorial_to_horizontal_core_tb;
  import e2h_pkg::*;

  localparam longint HALF_PI_R = 843314857;
  localparam longint PI_R      = 1686629713;
  localparam longint GAIN_R    = 652032874;
  localparam longint ONE_R     = 64'sd1 << 30;
  localparam int     STAGES    = 30;
  localparam int     LATENCY   = 3 * STAGES + 104;
  localparam longint LIMIT     = 400000;

  class horizon_scoreboard;
    longint    lat;
    out_item_t pending_q[$];
    int        errors;
    int        matched;
    int        undef_seen;

    function new();
      lat = LAT_RESET;
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    function longint arc_step(int i);
      longint t[10] = '{421657428, 248918915, 131521918, 66762579, 33510843,
                        16771758, 8387925, 4194219, 2097141, 1048575};
      if (i < 10) return t[i];
      if (i < 30) return 64'sd1 << (29 - i);
      return 0;
    endfunction

    function longint int_sqrt(longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return longint'(r);
    endfunction

    function longint cos_from_sin(longint s);
      longint unsigned sq;
      sq = longint'(s * s);
      return int_sqrt((64'd1 << 60) - sq);
    endfunction

    function void rotate(longint a, output longint s, output longint c);
      longint x, y, dx, dy;
      bit flip;
      x = GAIN_R;
      y = 0;
      flip = 0;
      if (a > HALF_PI_R) begin
        a -= PI_R;
        flip = 1;
      end else if (a < -HALF_PI_R) begin
        a += PI_R;
        flip = 1;
      end
      for (int i = 0; i < STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (a >= 0) begin
          x -= dx; y += dy; a -= arc_step(i);
        end else begin
          x += dx; y -= dy; a += arc_step(i);
        end
      end
      s = flip ? -y : y;
      c = flip ? -x : x;
    endfunction

    function longint arcsin(longint s);
      longint x, y, z, dx, dy;
      x = cos_from_sin(s);
      y = s;
      z = 0;
      for (int i = 0; i < STAGES; i++) begin
        dx = y >>> i;
        dy = x >>> i;
        if (y >= 0) begin
          x += dx; y -= dy; z += arc_step(i);
        end else begin
          x -= dx; y += dy; z -= arc_step(i);
        end
      end
      if (z > HALF_PI_R) z = HALF_PI_R;
      if (z < -HALF_PI_R) z = -HALF_PI_R;
      return z;
    endfunction

    function longint clamp_unit(longint v);
      if (v > ONE_R) return ONE_R;
      if (v < -ONE_R) return -ONE_R;
      return v;
    endfunction

    function void note_request(in_item_t d);
      longint sd, cd, sl, cl, sh, ch, s, alt, ca, num, den, az;
      out_item_t e;
      rotate(longint'(d.declination), sd, cd);
      rotate(lat, sl, cl);
      rotate(longint'(d.hour_angle), sh, ch);
      s = clamp_unit(((sd * sl) >>> 30) + ((((cd * cl) >>> 30) * ch) >>> 30));
      alt = arcsin(s);
      ca = cos_from_sin(s);
      den = (ca * cl) >>> 30;
      num = sd - ((s * sl) >>> 30);
      az = 0;
      e.azimuth_undefined = (den == 0);
      if (den != 0) begin
        az = HALF_PI_R - arcsin(clamp_unit((num * ONE_R) / den));
        if (az < 0) az = 0;
        if (az > PI_R) az = PI_R;
      end
      e.altitude = alt[30:0];
      e.azimuth = az[30:0];
      pending_q.push_back(e);
    endfunction

    task check_result(out_item_t g);
      out_item_t e;
      if (pending_q.size() == 0) begin
        report($sformatf("unexpected result %h", g));
        return;
      end
      e = pending_q.pop_front();
      if (g.altitude !== e.altitude)
        report($sformatf("altitude got %0d want %0d", g.altitude, e.altitude));
      if (g.azimuth !== e.azimuth)
        report($sformatf("azimuth got %0d want %0d", g.azimuth, e.azimuth));
      if (g.azimuth_undefined !== e.azimuth_undefined)
        report($sformatf("undefined flag got %b want %b",
                         g.azimuth_undefined, e.azimuth_undefined));
      matched++;
      if (e.azimuth_undefined) undef_seen++;
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 0;
  out_item_t   out_data;
  logic        psel = 0;
  logic        penable = 0;
  logic        pwrite = 0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  horizon_scoreboard sb = new();
  longint cycles = 0;
  int send_pct = 0;
  int recv_pct = 0;
  bit hold_req = 0;
  int requests = 0;

  equatorial_to_horizontal_core #(.CORDIC_STAGES(STAGES)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  // receiver stalls, with a long hold-off on request
  always @(posedge clk) begin
    int hold;
    if (hold_req && hold == 0) hold = 4 * LATENCY;
    if (hold > 0) begin
      hold--;
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      sb.note_request(in_data);
      requests++;
    end
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  task write_latitude(longint v);
    @(posedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= {REG_LATITUDE, 2'b00};
    pwdata <= 32'(v);
    @(posedge clk);
    penable <= 1;
    @(posedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.lat = longint'(signed'(v[30:0]));
  endtask

  task send_request(longint dec, longint ha);
    if ($urandom_range(99) < send_pct) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1;
    in_data.declination <= dec[30:0];
    in_data.hour_angle <= ha[31:0];
    do @(posedge clk); while (in_stall);
  endtask

  task drain;
    in_valid <= 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function longint rand_angle(longint lim, int bits);
    if ($urandom_range(9) == 0)
      return longint'($urandom) - (64'sd1 << (bits - 1)) % (64'sd1 << bits);
    return longint'($urandom_range(2 * lim)) - lim;
  endfunction

  initial begin
    longint lats[5];
    longint decs[7];
    longint has[7];
    lats = '{491933666, -843314857, 843314857, 0, 0};
    lats[4] = rand_angle(HALF_PI_R, 31);
    decs = '{-843314857, 843314857, 0, -(64'sd1 << 30), (64'sd1 << 30) - 1, 1, -1};
    has = '{-1686629713, 1686629713, 0, -(64'sd1 << 31), (64'sd1 << 31) - 1,
            843314857, -843314857};
    repeat (10) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed corners at the reset latitude
    for (int i = 0; i < 7; i++) send_request(decs[i], has[i]);
    for (int i = 0; i < 7; i++) send_request(decs[(i + 3) % 7], has[i]);
    send_request(HALF_PI_R, 0);
    send_request(-HALF_PI_R, PI_R);
    drain();

    for (int p = 0; p < 5; p++) begin
      write_latitude(lats[p]);
      send_pct = (p < 2) ? 31 : (p < 4) ? 83 : 0;
      recv_pct = (p < 2) ? 83 : (p < 4) ? 31 : 0;
      // one-cycle pulse starts the long receiver hold-off
      if (p == 4) begin
        hold_req <= 1;
        @(posedge clk);
        hold_req <= 0;
      end
      for (int k = 0; k < 76; k++) begin
        send_request(rand_angle(HALF_PI_R, 31), rand_angle(PI_R, 32));
      end
      drain();
    end

    $display("converted %0d requests over 6 latitude settings, %0d results checked",
             requests, sb.matched);
    $display("zero-divisor results seen: %0d, mismatches: %0d",
             sb.undef_seen, sb.errors);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end
endmodule
